@@ hw/rtl/hdlf_pkg.sv @@
// shared types and constants for the hashed duplicate line filter
package hdlf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned BUCKET_W = 16;
  localparam int unsigned OLEN_W   = 6;

  localparam int unsigned DEF_INDEX_BITS = 16;
  localparam int unsigned DEF_MAX_RECORD = 39;

  localparam logic [HASH_W-1:0] HASH_START   = HASH_W'(5381);
  localparam logic [BYTE_W-1:0] BYTE_NEWLINE = BYTE_W'(8'h0A);
  localparam logic [BYTE_W-1:0] BYTE_NUL     = BYTE_W'(8'h00);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  len;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hw/rtl/hdlf_chan_if.sv @@
// word channel interfaces for the byte input and the record result
interface hdlf_in_if;
  import hdlf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              end_of_stream;

  modport source (output valid, output byte_value, output end_of_stream, input ready);
  modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface hdlf_out_if;
  import hdlf_pkg::*;

  logic                valid;
  logic                ready;
  logic                first_seen;
  logic [BUCKET_W-1:0] bucket;
  logic [HASH_W-1:0]   record_hash;
  logic [OLEN_W-1:0]   record_length;

  modport source (output valid, output first_seen, output bucket, output record_hash,
                  output record_length, input ready);
  modport sink   (input valid, input first_seen, input bucket, input record_hash,
                  input record_length, output ready);
endinterface

@@ hw/rtl/hdlf_queue.sv @@
// short record queue between the front and back parts
module hdlf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  hdlf_pkg::q_push_t push,
  input  logic             pop,
  output hdlf_pkg::rec_t   head,
  output hdlf_pkg::q_stat_t stat
);
  import hdlf_pkg::*;

  rec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push.valid) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

@@ hw/rtl/hdlf_front.sv @@
// front part: byte intake, djb2 hashing and record framing
module hdlf_front #(
  parameter int unsigned MAX_RECORD = hdlf_pkg::DEF_MAX_RECORD
) (
  input  logic              clk,
  input  logic              rst_n,
  hdlf_in_if.sink           in_chan,
  input  logic              clr_done,
  input  hdlf_pkg::q_stat_t q_stat,
  output hdlf_pkg::q_push_t q_push
);
  import hdlf_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_RECORD);

  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              zero_r, zero_nxt;
  logic [HASH_W-1:0] hash_upd;
  logic [LEN_W-1:0]  cnt_inc;
  logic              accept;
  logic              closes;

  assign in_chan.ready = clr_done && !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    zero_nxt = zero_r || (in_chan.byte_value == BYTE_NUL);
    hash_upd = zero_nxt ? hash_r
                        : {hash_r[HASH_W-6:0], 5'b0} + hash_r + HASH_W'(in_chan.byte_value);
    cnt_inc  = cnt_r + LEN_W'(1);
    closes   = (in_chan.byte_value == BYTE_NEWLINE) || in_chan.end_of_stream ||
               (cnt_inc >= LEN_MAX);
    hash_nxt = hash_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (closes) begin
        hash_nxt = HASH_START;
        cnt_nxt  = '0;
        zero_nxt = 1'b0;
      end else begin
        hash_nxt = hash_upd;
        cnt_nxt  = cnt_inc;
      end
    end else begin
      zero_nxt = zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_START;
      cnt_r  <= '0;
      zero_r <= 1'b0;
    end else begin
      hash_r <= hash_nxt;
      cnt_r  <= cnt_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign q_push.valid    = accept && closes;
  assign q_push.rec.hash = hash_upd;
  assign q_push.rec.len  = cnt_inc;

endmodule

@@ hw/rtl/hdlf_back.sv @@
// back part: seen-bitmap clearing pass, test-and-set and result register
module hdlf_back #(
  parameter int unsigned INDEX_BITS = hdlf_pkg::DEF_INDEX_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hdlf_pkg::rec_t    q_head,
  input  hdlf_pkg::q_stat_t q_stat,
  output logic              q_pop,
  output logic              clr_done,
  hdlf_out_if.source        out_chan
);
  import hdlf_pkg::*;

  localparam logic [INDEX_BITS-1:0] IDX_LAST = {INDEX_BITS{1'b1}};

  logic bitmap_mem [2**INDEX_BITS];

  logic [INDEX_BITS-1:0] clr_idx_r;
  logic                  clr_done_r;

  rec_t                  s1_rec_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_fwd_r;
  logic                  rd_bit_r;
  logic [INDEX_BITS-1:0] s1_idx;
  logic [INDEX_BITS-1:0] pop_idx;
  logic                  s1_adv;

  logic                  we;
  logic [INDEX_BITS-1:0] waddr;
  logic                  wdata;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_first_r;
  logic [BUCKET_W-1:0]   out_bucket_r;
  logic [HASH_W-1:0]     out_hash_r;
  logic [OLEN_W-1:0]     out_len_r;

  assign clr_done = clr_done_r;
  assign s1_idx   = s1_rec_r.hash[INDEX_BITS-1:0];
  assign pop_idx  = q_head.hash[INDEX_BITS-1:0];
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign q_pop    = clr_done_r && !q_stat.empty && (!s1_valid_r || s1_adv);

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      clr_idx_r <= clr_idx_r + INDEX_BITS'(1);
      if (clr_idx_r == IDX_LAST) begin
        clr_done_r <= 1'b1;
      end
    end
  end

  always_comb begin
    if (!clr_done_r) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      wdata = 1'b0;
    end else begin
      we    = s1_adv;
      waddr = s1_idx;
      wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      bitmap_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_bit_r <= bitmap_mem[pop_idx];
    end
  end

  // lookup stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (q_pop) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_rec_r <= q_head;
      s1_fwd_r <= s1_adv && (s1_idx == pop_idx);
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_first_r  <= !(rd_bit_r || s1_fwd_r);
      out_bucket_r <= BUCKET_W'(s1_idx);
      out_hash_r   <= s1_rec_r.hash;
      out_len_r    <= s1_rec_r.len[OLEN_W-1:0];
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.first_seen    = out_first_r;
  assign out_chan.bucket        = out_bucket_r;
  assign out_chan.record_hash   = out_hash_r;
  assign out_chan.record_length = out_len_r;

endmodule

@@ hw/rtl/hashed_duplicate_line_filter.sv @@
// Hashed duplicate line filter: takes one byte word per cycle while the record queue has room,
// cuts the stream into records (newline, MAX_RECORD bytes or end of stream), hashes each with
// djb2 and reports per record whether its bucket in a 2**INDEX_BITS bit seen-bitmap was
// still clear, then marks it. A result word passes the record queue, lookup stage and result
// register. The bitmap is a single-port-write memory read on entry to the lookup stage and
// set on exit, with a bypass so records may close in consecutive cycles. After reset a
// clearing pass writes every bitmap entry, one per cycle, while in_chan.ready stays low.
module hashed_duplicate_line_filter #(
  parameter int unsigned INDEX_BITS = hdlf_pkg::DEF_INDEX_BITS,
  parameter int unsigned MAX_RECORD = hdlf_pkg::DEF_MAX_RECORD
) (
  input  logic        clk,
  input  logic        rst_n,
  hdlf_in_if.sink     in_chan,
  hdlf_out_if.source  out_chan
);
  import hdlf_pkg::*;

  q_push_t q_push;
  q_stat_t q_stat;
  rec_t    q_head;
  logic    q_pop;
  logic    clr_done;

  hdlf_front #(
    .MAX_RECORD (MAX_RECORD)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .clr_done (clr_done),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  hdlf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  hdlf_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .clr_done (clr_done),
    .out_chan (out_chan)
  );

endmodule

@@ tb/sv/tb_hashed_duplicate_line_filter.sv @@
// testbench for the hashed duplicate line filter: byte stream in, per-record bucket verdicts out
`timescale 1ns / 1ps

module tb_hashed_duplicate_line_filter;
  import hdlf_pkg::*;

  localparam int unsigned STALL_LIMIT  = 200000;
  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned VOCAB_LINES  = 8;
  localparam int unsigned VOCAB_MAX    = 12;

  typedef struct {
    logic                first_seen;
    logic [BUCKET_W-1:0] bucket;
    logic [HASH_W-1:0]   hash;
    logic [OLEN_W-1:0]   len;
  } record_verdict_t;

  typedef enum {
    REC_VOCAB,
    REC_FRESH,
    REC_LONG,
    REC_FULL_LINE,
    REC_WITH_NUL,
    REC_NOISE
  } record_kind_t;

  class record_tracker;
    logic [HASH_W-1:0] hash_acc;
    int unsigned       byte_count;
    bit                nul_seen;
    bit                seen_marks[];
    record_verdict_t   pending_verdicts[$];
    int unsigned       error_count;

    function new();
      seen_marks  = new[1 << DEF_INDEX_BITS];
      error_count = 0;
      restart();
    endfunction

    function void restart();
      hash_acc   = HASH_START;
      byte_count = 0;
      nul_seen   = 1'b0;
    endfunction

    function void absorb_byte(logic [BYTE_W-1:0] b, logic eos);
      record_verdict_t   v;
      logic [HASH_W-1:0] idx;
      if (b == BYTE_NUL) nul_seen = 1'b1;
      if (!nul_seen) hash_acc = (hash_acc << 5) + hash_acc + HASH_W'(b);
      byte_count++;
      if (b == BYTE_NEWLINE || eos || byte_count >= DEF_MAX_RECORD) begin
        idx = hash_acc & ((HASH_W'(1) << DEF_INDEX_BITS) - HASH_W'(1));
        v.first_seen = !seen_marks[idx];
        seen_marks[idx] = 1'b1;
        v.bucket = BUCKET_W'(idx);
        v.hash = hash_acc;
        v.len = OLEN_W'(byte_count);
        pending_verdicts.push_back(v);
        restart();
      end
    endfunction

    function void compare_record(logic fs, logic [BUCKET_W-1:0] bk, logic [HASH_W-1:0] h,
                                 logic [OLEN_W-1:0] len);
      record_verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result word: first_seen %0b bucket %h hash %h length %0d",
                 $time, fs, bk, h, len);
        error_count++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (fs !== v.first_seen) begin
        $display("%0t: first_seen expected %0b actual %0b", $time, v.first_seen, fs);
        error_count++;
      end
      if (bk !== v.bucket) begin
        $display("%0t: bucket expected %h actual %h", $time, v.bucket, bk);
        error_count++;
      end
      if (h !== v.hash) begin
        $display("%0t: record_hash expected %h actual %h", $time, v.hash, h);
        error_count++;
      end
      if (len !== v.len) begin
        $display("%0t: record_length expected %0d actual %0d", $time, v.len, len);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hdlf_in_if  in_chan();
  hdlf_out_if out_chan();

  hashed_duplicate_line_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  record_tracker tracker = new();

  int unsigned bytes_sent = 0;
  int unsigned idle_pct   = 32;
  int unsigned stall_pct  = 82;
  int unsigned quiet_cycles = 0;

  logic [BYTE_W-1:0] vocab_text [VOCAB_LINES][VOCAB_MAX];
  int unsigned       vocab_len  [VOCAB_LINES];

  always #10 clk = ~clk;

  initial begin
    in_chan.valid         = 1'b0;
    in_chan.byte_value    = '0;
    in_chan.end_of_stream = 1'b0;
    out_chan.ready        = 1'b0;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      tracker.compare_record(out_chan.first_seen, out_chan.bucket, out_chan.record_hash,
                             out_chan.record_length);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    do begin
      b = BYTE_W'($urandom_range(255, 1));
    end while (b == BYTE_NEWLINE);
    return b;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
    if (bytes_sent < 170) begin
      idle_pct  = 32;
      stall_pct = 82;
    end else if (bytes_sent < 340) begin
      idle_pct  = 82;
      stall_pct = 32;
    end else begin
      idle_pct  = 0;
      stall_pct = 0;
    end
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.byte_value    <= b;
    in_chan.end_of_stream <= eos;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    tracker.absorb_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_record(input record_kind_t kind);
    int unsigned n;
    int unsigned pick;
    int unsigned nul_at;
    logic        eos_last;
    eos_last = ($urandom_range(9) == 0);
    case (kind)
      REC_VOCAB: begin
        pick = $urandom_range(VOCAB_LINES - 1);
        for (int i = 0; i < vocab_len[pick]; i++) send_byte(vocab_text[pick][i], 1'b0);
        send_byte(BYTE_NEWLINE, eos_last);
      end
      REC_FRESH: begin
        n = $urandom_range(20);
        for (int i = 0; i < n; i++) send_byte(text_byte(), 1'b0);
        send_byte(BYTE_NEWLINE, eos_last);
      end
      REC_LONG: begin
        n = $urandom_range(DEF_MAX_RECORD + 20, DEF_MAX_RECORD);
        for (int i = 0; i < n; i++) send_byte(text_byte(), (i == n - 1) && eos_last);
      end
      REC_FULL_LINE: begin
        for (int i = 0; i < DEF_MAX_RECORD - 1; i++) send_byte(text_byte(), 1'b0);
        send_byte(BYTE_NEWLINE, eos_last);
      end
      REC_WITH_NUL: begin
        n = $urandom_range(15, 1);
        nul_at = $urandom_range(n - 1);
        for (int i = 0; i < n; i++) send_byte((i == nul_at) ? BYTE_NUL : text_byte(), 1'b0);
        send_byte(BYTE_NEWLINE, eos_last);
      end
      default: begin
        n = $urandom_range(10, 1);
        for (int i = 0; i < n; i++) begin
          send_byte(BYTE_W'($urandom_range(255)), ($urandom_range(7) == 0));
        end
      end
    endcase
  endtask

  initial begin
    int unsigned roll;
    int unsigned target;
    for (int i = 0; i < VOCAB_LINES; i++) begin
      vocab_len[i] = $urandom_range(VOCAB_MAX);
      for (int j = 0; j < VOCAB_MAX; j++) vocab_text[i][j] = text_byte();
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty line twice, the second lands in a marked bucket
    send_byte(BYTE_NEWLINE, 1'b0);
    send_byte(BYTE_NEWLINE, 1'b0);
    send_byte(8'hFF, 1'b1);
    // hashing stops at the nul, so both lines share one hash
    send_byte(8'h61, 1'b0);
    send_byte(BYTE_NUL, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(BYTE_NEWLINE, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(BYTE_NUL, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(BYTE_NEWLINE, 1'b0);
    send_byte(BYTE_NUL, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(BYTE_NEWLINE, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(BYTE_NEWLINE, 1'b0);

    send_record(REC_LONG);
    send_record(REC_FULL_LINE);
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 40) send_record(REC_VOCAB);
      else if (roll < 68) send_record(REC_FRESH);
      else if (roll < 76) send_record(REC_LONG);
      else if (roll < 82) send_record(REC_FULL_LINE);
      else if (roll < 92) send_record(REC_WITH_NUL);
      else send_record(REC_NOISE);
    end
    // flush any open record
    send_byte(BYTE_NEWLINE, 1'b1);
    in_chan.valid <= 1'b0;

    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
